@@ rtl/core/structured_cube_element_connectivity_macros.svh @@
// Assertion macros shared by the connectivity block.
`ifndef STRUCTURED_CUBE_ELEMENT_CONNECTIVITY_MACROS_SVH
`define STRUCTURED_CUBE_ELEMENT_CONNECTIVITY_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define SCED_ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define SCED_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/core/sced_pkg.sv @@
// Shared types and constants of the cube element connectivity block.
package sced_pkg;

   localparam int COORD_W           = 6;
   localparam int NODE_W            = 19;
   localparam int CSR_DATA_W        = 7;
   localparam int MAX_CELLS_DEFAULT = 64;
   localparam int QUEUE_DEPTH_DEF   = 4;
   localparam int TET_W             = 3;
   localparam int RING_N            = 6;

   localparam logic [TET_W-1:0] TET_LAST = TET_W'(RING_N - 1);

   typedef enum logic [1:0] {
      CSR_CELLS_X      = 2'd0,
      CSR_CELLS_Y      = 2'd1,
      CSR_CELLS_Z      = 2'd2,
      CSR_ELEMENT_KIND = 2'd3
   } csr_index_type;

   // One classified cell handed from the front to the back.
   typedef struct packed {
      logic [NODE_W-1:0] base;
      logic [NODE_W-1:0] stride_y;
      logic [NODE_W-1:0] stride_z;
      logic              is_hex;
      logic              err;
   } cell_job_type;

endpackage

@@ rtl/core/sced_if.sv @@
// Channel interfaces: cell requests, element results and register writes.
interface sced_req_if;
   import sced_pkg::*;
   logic               valid;
   logic               ready;
   logic [COORD_W-1:0] cell_x;
   logic [COORD_W-1:0] cell_y;
   logic [COORD_W-1:0] cell_z;
   modport source (output valid, cell_x, cell_y, cell_z, input ready);
   modport sink (input valid, cell_x, cell_y, cell_z, output ready);
endinterface

interface sced_rsp_if;
   import sced_pkg::*;
   logic              valid;
   logic              ready;
   logic [NODE_W-1:0] node_a;
   logic [NODE_W-1:0] node_b;
   logic [NODE_W-1:0] node_c;
   logic [NODE_W-1:0] node_d;
   logic [NODE_W-1:0] node_e;
   logic [NODE_W-1:0] node_f;
   logic [NODE_W-1:0] node_g;
   logic [NODE_W-1:0] node_h;
   logic              is_hex;
   logic              last_of_cell;
   logic              cell_error;
   modport source (output valid, node_a, node_b, node_c, node_d, node_e, node_f,
                   node_g, node_h, is_hex, last_of_cell, cell_error, input ready);
   modport sink (input valid, node_a, node_b, node_c, node_d, node_e, node_f,
                 node_g, node_h, is_hex, last_of_cell, cell_error, output ready);
endinterface

interface sced_csr_if;
   import sced_pkg::*;
   logic                  valid;
   logic                  ready;
   csr_index_type         index;
   logic [CSR_DATA_W-1:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

@@ rtl/core/structured_cube_element_connectivity.sv @@
// Path: a request beat is registered in front stages s1 and s2, queued, loaded into
// the working cell and sent from the single output register, one element per cycle
// while rsp_bus.ready holds: one cell per cycle in hex mode or on error, six tets per cell in tet mode.
// The front pipeline and the 4-entry job queue keep taking cells while results wait.
// Reset (synchronous, active high) empties the pipeline and the queue and sets
// the grid to 1 x 1 x 1 cells in tet mode.
module structured_cube_element_connectivity #(
   parameter int MAX_CELLS_PER_AXIS = sced_pkg::MAX_CELLS_DEFAULT,
   parameter int QUEUE_DEPTH        = sced_pkg::QUEUE_DEPTH_DEF
) (
   input  logic       clock,
   input  logic       reset,
   sced_req_if.sink   req_bus,
   sced_rsp_if.source rsp_bus,
   sced_csr_if.sink   csr_bus
);
   import sced_pkg::*;

`include "structured_cube_element_connectivity_macros.svh"

   cell_job_type q_wdata, q_rdata;
   logic         q_push, q_pop, q_full, q_valid;

   sced_front #(
      .MAX_CELLS_PER_AXIS (MAX_CELLS_PER_AXIS)
   ) u_front (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .csr_bus (csr_bus),
      .q_wdata (q_wdata),
      .q_push  (q_push),
      .q_full  (q_full)
   );

   sced_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .wdata     (q_wdata),
      .pop       (q_pop),
      .rdata     (q_rdata),
      .full      (q_full),
      .not_empty (q_valid)
   );

   sced_back u_back (
      .clock   (clock),
      .reset   (reset),
      .q_rdata (q_rdata),
      .q_valid (q_valid),
      .q_pop   (q_pop),
      .rsp_bus (rsp_bus)
   );

   // An error beat carries no nodes and closes its cell.
   `SCED_ASSERT_IMPLY(a_err_clean, clock, reset, rsp_bus.valid && rsp_bus.cell_error, rsp_bus.last_of_cell && !rsp_bus.is_hex && rsp_bus.node_a == '0 && rsp_bus.node_d == '0 && rsp_bus.node_h == '0, "error beat not clean")
   // A tet leaves the upper four nodes at zero.
   `SCED_ASSERT_IMPLY(a_tet_pad, clock, reset, rsp_bus.valid && !rsp_bus.is_hex, rsp_bus.node_e == '0 && rsp_bus.node_f == '0 && rsp_bus.node_g == '0 && rsp_bus.node_h == '0, "tet padding not zero")
   // A hex is the only element of its cell.
   `SCED_ASSERT_IMPLY(a_hex_last, clock, reset, rsp_bus.valid && rsp_bus.is_hex, rsp_bus.last_of_cell && !rsp_bus.cell_error, "hex beat not last")
   // Elements of one cell follow without a gap.
   `SCED_ASSERT_NEXT(a_cell_burst, clock, reset, rsp_bus.valid && rsp_bus.ready && !rsp_bus.last_of_cell, rsp_bus.valid && !rsp_bus.is_hex, "gap inside a cell")

endmodule

@@ rtl/core/sced_front.sv @@
// Front end: grid registers, bounds check and base node id pipeline.
module sced_front #(
   parameter int MAX_CELLS_PER_AXIS = sced_pkg::MAX_CELLS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   sced_req_if.sink              req_bus,
   sced_csr_if.sink              csr_bus,
   output sced_pkg::cell_job_type q_wdata,
   output logic                  q_push,
   input  logic                  q_full
);
   import sced_pkg::*;

   localparam int CNT_W   = $clog2(MAX_CELLS_PER_AXIS + 1);
   localparam int CLAMP_W = (CNT_W > CSR_DATA_W) ? CNT_W : CSR_DATA_W;
   localparam int CMP_W   = (CNT_W > COORD_W) ? CNT_W : COORD_W;

   // Saturate a written count at the axis maximum.
   function automatic logic [CNT_W-1:0] clamp_count(input logic [CSR_DATA_W-1:0] v);
      logic [CLAMP_W-1:0] wide;
      wide = CLAMP_W'(v);
      if (wide > CLAMP_W'(MAX_CELLS_PER_AXIS)) begin
         wide = CLAMP_W'(MAX_CELLS_PER_AXIS);
      end
      return CNT_W'(wide);
   endfunction

   logic [CNT_W-1:0] cells_x_ff, cells_y_ff, cells_z_ff;
   logic             hex_mode_ff;

   logic               s1_valid_ff, s1_err_ff, s1_hex_ff;
   logic [COORD_W-1:0] s1_x_ff, s1_y_ff, s1_z_ff;
   logic               s2_valid_ff, s2_err_ff, s2_hex_ff;
   logic [COORD_W-1:0] s2_x_ff;
   logic [NODE_W-1:0]  s2_zy_ff;

   logic              req_beat, err_in, s1_adv, s2_adv, s1_free, s2_free;
   logic [NODE_W-1:0] px, py, zy_in;

   // Register writes are always taken.
   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cells_x_ff  <= CNT_W'(1);
         cells_y_ff  <= CNT_W'(1);
         cells_z_ff  <= CNT_W'(1);
         hex_mode_ff <= 1'b0;
      end else if (csr_bus.valid) begin
         unique case (csr_bus.index)
            CSR_CELLS_X:      cells_x_ff  <= clamp_count(csr_bus.data);
            CSR_CELLS_Y:      cells_y_ff  <= clamp_count(csr_bus.data);
            CSR_CELLS_Z:      cells_z_ff  <= clamp_count(csr_bus.data);
            CSR_ELEMENT_KIND: hex_mode_ff <= csr_bus.data[0];
         endcase
      end
   end

   // Stall chain: each stage advances when the one after it has room.
   assign s2_adv        = s2_valid_ff && !q_full;
   assign s2_free       = !s2_valid_ff || s2_adv;
   assign s1_adv        = s1_valid_ff && s2_free;
   assign s1_free       = !s1_valid_ff || s1_adv;
   assign req_bus.ready = s1_free;
   assign req_beat      = req_bus.valid && s1_free;

   // Classify the cell against the grid.
   assign err_in = (CMP_W'(req_bus.cell_x) >= CMP_W'(cells_x_ff))
                || (CMP_W'(req_bus.cell_y) >= CMP_W'(cells_y_ff))
                || (CMP_W'(req_bus.cell_z) >= CMP_W'(cells_z_ff));

   // Node pitches along x and y.
   assign px    = NODE_W'(cells_x_ff) + NODE_W'(1);
   assign py    = NODE_W'(cells_y_ff) + NODE_W'(1);
   assign zy_in = NODE_W'(s1_z_ff) * py + NODE_W'(s1_y_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         if (s1_free) begin
            s1_valid_ff <= req_bus.valid;
         end
         if (s2_free) begin
            s2_valid_ff <= s1_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_beat) begin
         s1_x_ff   <= req_bus.cell_x;
         s1_y_ff   <= req_bus.cell_y;
         s1_z_ff   <= req_bus.cell_z;
         s1_err_ff <= err_in;
         s1_hex_ff <= hex_mode_ff;
      end
      if (s1_adv) begin
         s2_zy_ff  <= zy_in;
         s2_x_ff   <= s1_x_ff;
         s2_err_ff <= s1_err_ff;
         s2_hex_ff <= s1_hex_ff;
      end
   end

   // Finish the base id and the strides, then queue the job.
   assign q_push            = s2_adv;
   assign q_wdata.base      = s2_zy_ff * px + NODE_W'(s2_x_ff);
   assign q_wdata.stride_y  = px;
   assign q_wdata.stride_z  = px * py;
   assign q_wdata.is_hex    = s2_hex_ff;
   assign q_wdata.err       = s2_err_ff;

endmodule

@@ rtl/core/sced_queue.sv @@
// Short job queue between the front and back ends.
module sced_queue #(
   parameter int DEPTH = sced_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  sced_pkg::cell_job_type wdata,
   input  logic                   pop,
   output sced_pkg::cell_job_type rdata,
   output logic                   full,
   output logic                   not_empty
);
   import sced_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   cell_job_type     entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0] count_ff;

   // Advance a pointer with wrap at the depth.
   function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
      return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
   endfunction

   assign full      = (count_ff == CNT_W'(DEPTH));
   assign not_empty = (count_ff != '0);
   assign rdata     = entry_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= bump(wr_ptr_ff);
         end
         if (pop) begin
            rd_ptr_ff <= bump(rd_ptr_ff);
         end
         if (push && !pop) begin
            count_ff <= count_ff + CNT_W'(1);
         end else if (pop && !push) begin
            count_ff <= count_ff - CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= wdata;
      end
   end

endmodule

@@ rtl/core/sced_back.sv @@
// Back end: expands one job into its elements, one element per cycle while rsp_bus.ready holds.
module sced_back (
   input  logic                   clock,
   input  logic                   reset,
   input  sced_pkg::cell_job_type q_rdata,
   input  logic                   q_valid,
   output logic                   q_pop,
   sced_rsp_if.source             rsp_bus
);
   import sced_pkg::*;

   // Working cell: corner nodes and the ring of side nodes around the diagonal.
   logic              w_valid_ff, w_err_ff, w_hex_ff;
   logic [TET_W-1:0]  w_tet_ff;
   logic [NODE_W-1:0] w_c000_ff, w_c111_ff;
   logic [NODE_W-1:0] w_ring_ff [RING_N];

   logic              rsp_valid_ff, is_hex_ff, last_ff, err_ff;
   logic [NODE_W-1:0] na_ff, nb_ff, nc_ff, nd_ff, ne_ff, nf_ff, ng_ff, nh_ff;
   logic              is_hex_in, last_in, err_in;
   logic [NODE_W-1:0] na_in, nb_in, nc_in, nd_in, ne_in, nf_in, ng_in, nh_in;

   logic              out_adv, emit, w_last, load;
   logic [NODE_W-1:0] b_sy, b_sz, b_syz;

   assign out_adv = !rsp_valid_ff || rsp_bus.ready;
   assign emit    = out_adv && w_valid_ff;
   assign w_last  = w_err_ff || w_hex_ff || (w_tet_ff == TET_LAST);
   assign load    = q_valid && (!w_valid_ff || (emit && w_last));
   assign q_pop   = load;

   assign b_sy  = q_rdata.base + q_rdata.stride_y;
   assign b_sz  = q_rdata.base + q_rdata.stride_z;
   assign b_syz = b_sy + q_rdata.stride_z;

   always_ff @(posedge clock) begin
      if (reset) begin
         w_valid_ff <= 1'b0;
         w_tet_ff   <= '0;
      end else if (load) begin
         w_valid_ff <= 1'b1;
         w_tet_ff   <= '0;
      end else if (emit) begin
         w_valid_ff <= !w_last;
         w_tet_ff   <= w_tet_ff + TET_W'(1);
      end
   end

   // Load the corners of a new cell, or rotate the ring after each tet.
   always_ff @(posedge clock) begin
      if (load) begin
         w_err_ff    <= q_rdata.err;
         w_hex_ff    <= q_rdata.is_hex;
         w_c000_ff   <= q_rdata.base;
         w_c111_ff   <= b_syz + NODE_W'(1);
         w_ring_ff[0] <= q_rdata.base + NODE_W'(1);
         w_ring_ff[1] <= b_sy + NODE_W'(1);
         w_ring_ff[2] <= b_sy;
         w_ring_ff[3] <= b_syz;
         w_ring_ff[4] <= b_sz;
         w_ring_ff[5] <= b_sz + NODE_W'(1);
      end else if (emit) begin
         for (int i = 0; i < RING_N - 1; i++) begin
            w_ring_ff[i] <= w_ring_ff[i+1];
         end
         w_ring_ff[RING_N-1] <= w_ring_ff[0];
      end
   end

   // Build the element for the current position.
   always_comb begin
      na_in     = '0;
      nb_in     = '0;
      nc_in     = '0;
      nd_in     = '0;
      ne_in     = '0;
      nf_in     = '0;
      ng_in     = '0;
      nh_in     = '0;
      is_hex_in = 1'b0;
      last_in   = w_last;
      err_in    = w_err_ff;
      if (!w_err_ff) begin
         na_in = w_c000_ff;
         nb_in = w_ring_ff[0];
         nc_in = w_ring_ff[1];
         if (w_hex_ff) begin
            is_hex_in = 1'b1;
            nd_in     = w_ring_ff[2];
            ne_in     = w_ring_ff[4];
            nf_in     = w_ring_ff[5];
            ng_in     = w_c111_ff;
            nh_in     = w_ring_ff[3];
         end else begin
            nd_in = w_c111_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_adv) begin
         rsp_valid_ff <= w_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         na_ff     <= na_in;
         nb_ff     <= nb_in;
         nc_ff     <= nc_in;
         nd_ff     <= nd_in;
         ne_ff     <= ne_in;
         nf_ff     <= nf_in;
         ng_ff     <= ng_in;
         nh_ff     <= nh_in;
         is_hex_ff <= is_hex_in;
         last_ff   <= last_in;
         err_ff    <= err_in;
      end
   end

   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.node_a       = na_ff;
   assign rsp_bus.node_b       = nb_ff;
   assign rsp_bus.node_c       = nc_ff;
   assign rsp_bus.node_d       = nd_ff;
   assign rsp_bus.node_e       = ne_ff;
   assign rsp_bus.node_f       = nf_ff;
   assign rsp_bus.node_g       = ng_ff;
   assign rsp_bus.node_h       = nh_ff;
   assign rsp_bus.is_hex       = is_hex_ff;
   assign rsp_bus.last_of_cell = last_ff;
   assign rsp_bus.cell_error   = err_ff;

endmodule
